@@ hdl/hvt_pkg.sv @@
// ----------------------------------------------------------------------------
// hvt_pkg
// Shared constants for the homogeneous vertex transform core.
// ----------------------------------------------------------------------------
package hvt_pkg;

  localparam int unsigned FRAC_BITS_DEF = 16;
  localparam int unsigned NUM_REGS      = 8;
  localparam int unsigned REG_W         = 64;
  localparam int unsigned ADDR_W        = 6;
  localparam int unsigned DIV_STEPS     = 4;   // quotient bits per divider stage

  // vertex commands
  localparam logic [1:0] CMD_POINT_DIV = 2'd0;
  localparam logic [1:0] CMD_DIRECTION = 2'd1;
  localparam logic [1:0] CMD_POINT_RAW = 2'd2;

  // result tuser bits
  localparam int unsigned TUSER_DZ_BIT  = 0;
  localparam int unsigned TUSER_SAT_BIT = 1;

endpackage

@@ hdl/homogeneous_vertex_transform_core.sv @@
// ----------------------------------------------------------------------------
// homogeneous_vertex_transform_core
// 4x4 fixed-point vertex transform with optional perspective divide.
// ----------------------------------------------------------------------------
// One vertex per clock in, one result per clock out. Each transfer is
// multiplied by a column-major 4x4 matrix (eight 64-bit APB registers, two
// elements each), summed at full width, floored by FRAC_BITS and saturated.
// Command 0 divides x/y/z by w (skipped and flagged when w is zero), command
// 1 treats the vertex as a direction (w input 0), commands 2 and 3 return the
// raw homogeneous point. The pipeline registers, in order: multiply, sum,
// shift/saturate, divide setup, the pipelined restoring divider stages of
// up to four quotient bits each, and the output register. All stages stall
// together when the output register is full and not taken.
// ----------------------------------------------------------------------------
module homogeneous_vertex_transform_core
  import hvt_pkg::*;
#(
  parameter int unsigned FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  // input vertices
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  input  logic [95:0]         s_axis_tdata,   // in_x, in_y, in_z
  input  logic [1:0]          s_axis_tuser,   // cmd
  // results
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  output logic [127:0]        m_axis_tdata,   // out_x, out_y, out_z, out_w
  output logic [1:0]          m_axis_tuser,   // div_by_zero, saturated
  // configuration
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [ADDR_W-1:0]   paddr,
  input  logic [REG_W-1:0]    pwdata,
  output logic [REG_W-1:0]    prdata,
  output logic                pready
);

  localparam int unsigned NUM_W  = 32 + FRAC_BITS;            // dividend / quotient bits
  localparam int unsigned DIV_ST = (NUM_W + DIV_STEPS - 1) / DIV_STEPS;
  localparam int unsigned REM_W  = 33;
  localparam int unsigned SUM_W  = 66;

  // --------------------------------------------------------------------------
  // Matrix registers
  // --------------------------------------------------------------------------
  logic [REG_W-1:0] m_q [NUM_REGS];

  assign pready = 1'b1;
  assign prdata = m_q[paddr[ADDR_W-1:3]];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < NUM_REGS; k++) m_q[k] <= '0;
      m_q[0] <= REG_W'(1) << FRAC_BITS;
      m_q[2] <= REG_W'(1) << (FRAC_BITS + 32);
      m_q[5] <= REG_W'(1) << FRAC_BITS;
      m_q[7] <= REG_W'(1) << (FRAC_BITS + 32);
    end else if (psel && penable && pwrite) begin
      m_q[paddr[ADDR_W-1:3]] <= pwdata;
    end
  end

  // element index = row + 4 * column
  logic signed [31:0] elem [16];
  always_comb begin
    for (int i = 0; i < 16; i++) begin
      elem[i] = (i % 2 == 1) ? m_q[i/2][63:32] : m_q[i/2][31:0];
    end
  end

  // --------------------------------------------------------------------------
  // Global pipeline advance
  // --------------------------------------------------------------------------
  logic out_vld_q;
  logic en;

  assign en            = !out_vld_q || m_axis_tready;
  assign s_axis_tready = en;

  // --------------------------------------------------------------------------
  // Stage 1: products
  // --------------------------------------------------------------------------
  logic signed [31:0] vin [3];
  assign vin[0] = s_axis_tdata[31:0];
  assign vin[1] = s_axis_tdata[63:32];
  assign vin[2] = s_axis_tdata[95:64];

  logic               p1_vld_q;
  logic [1:0]         p1_cmd_q;
  logic signed [63:0] p1_mul_q [4][3];
  logic signed [63:0] p1_wt_q  [4];

  // --------------------------------------------------------------------------
  // Stage 2: row sums, stage 3: floor shift and saturate
  // --------------------------------------------------------------------------
  logic                    p2_vld_q, p3_vld_q;
  logic [1:0]              p2_cmd_q, p3_cmd_q;
  logic signed [SUM_W-1:0] p2_sum_q [4];
  logic signed [31:0]      p3_res_q [4];
  logic                    p3_sat_q;

  logic signed [SUM_W-1:0] sh [4];
  logic signed [31:0]      res_d [4];
  logic                    sat_d;

  always_comb begin
    sat_d = 1'b0;
    for (int r = 0; r < 4; r++) begin
      sh[r] = p2_sum_q[r] >>> FRAC_BITS;
      if (sh[r][SUM_W-1:31] == '0 || sh[r][SUM_W-1:31] == '1) begin
        res_d[r] = sh[r][31:0];
      end else begin
        sat_d    = 1'b1;
        res_d[r] = sh[r][SUM_W-1] ? 32'sh8000_0000 : 32'sh7fff_ffff;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Divider pipeline: stage 0 sets up magnitudes, stages 1..DIV_ST each
  // produce up to DIV_STEPS quotient bits
  // --------------------------------------------------------------------------
  logic             dv_vld_q [DIV_ST+1];
  logic             dv_do_q  [DIV_ST+1];
  logic             dv_dz_q  [DIV_ST+1];
  logic             dv_sat_q [DIV_ST+1];
  logic [31:0]      dv_den_q [DIV_ST+1];
  logic [31:0]      dv_w_q   [DIV_ST+1];
  logic [31:0]      dv_raw_q [DIV_ST+1][3];
  logic             dv_neg_q [DIV_ST+1][3];
  logic [REM_W-1:0] dv_rem_q [DIV_ST+1][3];
  logic [NUM_W-1:0] dv_num_q [DIV_ST+1][3];
  logic [NUM_W-1:0] dv_quo_q [DIV_ST+1][3];

  logic [REM_W-1:0] rem_d [DIV_ST+1][3];
  logic [NUM_W-1:0] num_d [DIV_ST+1][3];
  logic [NUM_W-1:0] quo_d [DIV_ST+1][3];

  logic [31:0] w_mag;
  logic [31:0] c_mag [3];
  always_comb begin
    w_mag = p3_res_q[3][31] ? 32'(-p3_res_q[3]) : 32'(p3_res_q[3]);
    for (int l = 0; l < 3; l++) begin
      c_mag[l] = p3_res_q[l][31] ? 32'(-p3_res_q[l]) : 32'(p3_res_q[l]);
    end
  end

  for (genvar s = 1; s <= DIV_ST; s++) begin : g_div
    for (genvar l = 0; l < 3; l++) begin : g_lane
      always_comb begin
        logic [REM_W-1:0] r;
        logic [NUM_W-1:0] n;
        logic [NUM_W-1:0] q;
        r = dv_rem_q[s-1][l];
        n = dv_num_q[s-1][l];
        q = dv_quo_q[s-1][l];
        for (int j = 0; j < DIV_STEPS; j++) begin
          if ((s - 1) * DIV_STEPS + j < NUM_W) begin
            r = {r[REM_W-2:0], n[NUM_W-1]};
            n = {n[NUM_W-2:0], 1'b0};
            if (r >= {1'b0, dv_den_q[s-1]}) begin
              r = r - {1'b0, dv_den_q[s-1]};
              q = {q[NUM_W-2:0], 1'b1};
            end else begin
              q = {q[NUM_W-2:0], 1'b0};
            end
          end
        end
        rem_d[s][l] = r;
        num_d[s][l] = n;
        quo_d[s][l] = q;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Output stage: sign, saturate, select
  // --------------------------------------------------------------------------
  localparam logic [NUM_W-1:0] Q_MAX_POS = NUM_W'(32'h7fff_ffff);
  localparam logic [NUM_W-1:0] Q_MAX_NEG = NUM_W'(32'h8000_0000);

  logic [31:0] fin [3];
  logic        fin_sat;
  always_comb begin
    fin_sat = dv_sat_q[DIV_ST];
    for (int l = 0; l < 3; l++) begin
      if (!dv_do_q[DIV_ST]) begin
        fin[l] = dv_raw_q[DIV_ST][l];
      end else if (dv_neg_q[DIV_ST][l]) begin
        if (dv_quo_q[DIV_ST][l] > Q_MAX_NEG) begin
          fin[l]  = 32'h8000_0000;
          fin_sat = 1'b1;
        end else begin
          fin[l]  = 32'(-dv_quo_q[DIV_ST][l]);
        end
      end else begin
        if (dv_quo_q[DIV_ST][l] > Q_MAX_POS) begin
          fin[l]  = 32'h7fff_ffff;
          fin_sat = 1'b1;
        end else begin
          fin[l]  = dv_quo_q[DIV_ST][l][31:0];
        end
      end
    end
  end

  logic [127:0] out_data_q;
  logic [1:0]   out_user_q;

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = out_data_q;
  assign m_axis_tuser  = out_user_q;

  // valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p1_vld_q  <= 1'b0;
      p2_vld_q  <= 1'b0;
      p3_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
      for (int s = 0; s <= DIV_ST; s++) dv_vld_q[s] <= 1'b0;
    end else if (en) begin
      p1_vld_q    <= s_axis_tvalid;
      p2_vld_q    <= p1_vld_q;
      p3_vld_q    <= p2_vld_q;
      dv_vld_q[0] <= p3_vld_q;
      for (int s = 1; s <= DIV_ST; s++) dv_vld_q[s] <= dv_vld_q[s-1];
      out_vld_q   <= dv_vld_q[DIV_ST];
    end
  end

  // payload
  always_ff @(posedge clk_i) begin
    if (en) begin
      // stage 1
      p1_cmd_q <= s_axis_tuser;
      for (int r = 0; r < 4; r++) begin
        for (int c = 0; c < 3; c++) p1_mul_q[r][c] <= elem[r + 4*c] * vin[c];
        p1_wt_q[r] <= (s_axis_tuser == CMD_DIRECTION) ? 64'sd0 :
                      (64'(elem[r + 12]) <<< FRAC_BITS);
      end
      // stage 2
      p2_cmd_q <= p1_cmd_q;
      for (int r = 0; r < 4; r++) begin
        p2_sum_q[r] <= SUM_W'(p1_mul_q[r][0]) + SUM_W'(p1_mul_q[r][1])
                     + SUM_W'(p1_mul_q[r][2]) + SUM_W'(p1_wt_q[r]);
      end
      // stage 3
      p3_cmd_q <= p2_cmd_q;
      p3_sat_q <= sat_d;
      for (int r = 0; r < 4; r++) p3_res_q[r] <= res_d[r];
      // divider setup
      dv_do_q[0]  <= (p3_cmd_q == CMD_POINT_DIV) && (p3_res_q[3] != 32'sd0);
      dv_dz_q[0]  <= (p3_cmd_q == CMD_POINT_DIV) && (p3_res_q[3] == 32'sd0);
      dv_sat_q[0] <= p3_sat_q;
      dv_den_q[0] <= w_mag;
      dv_w_q[0]   <= p3_res_q[3];
      for (int l = 0; l < 3; l++) begin
        dv_raw_q[0][l] <= p3_res_q[l];
        dv_neg_q[0][l] <= p3_res_q[l][31] ^ p3_res_q[3][31];
        dv_rem_q[0][l] <= '0;
        dv_num_q[0][l] <= {c_mag[l], {FRAC_BITS{1'b0}}};
        dv_quo_q[0][l] <= '0;
      end
      // divider stages
      for (int s = 1; s <= DIV_ST; s++) begin
        dv_do_q[s]  <= dv_do_q[s-1];
        dv_dz_q[s]  <= dv_dz_q[s-1];
        dv_sat_q[s] <= dv_sat_q[s-1];
        dv_den_q[s] <= dv_den_q[s-1];
        dv_w_q[s]   <= dv_w_q[s-1];
        for (int l = 0; l < 3; l++) begin
          dv_raw_q[s][l] <= dv_raw_q[s-1][l];
          dv_neg_q[s][l] <= dv_neg_q[s-1][l];
          dv_rem_q[s][l] <= rem_d[s][l];
          dv_num_q[s][l] <= num_d[s][l];
          dv_quo_q[s][l] <= quo_d[s][l];
        end
      end
      // output register
      out_data_q <= {dv_w_q[DIV_ST], fin[2], fin[1], fin[0]};
      out_user_q[TUSER_DZ_BIT]  <= dv_dz_q[DIV_ST];
      out_user_q[TUSER_SAT_BIT] <= fin_sat;
    end
  end

endmodule

@@ hdl/hvt_checker.sv @@
// ----------------------------------------------------------------------------
// hvt_checker
// Port-level checks for the homogeneous vertex transform core.
// ----------------------------------------------------------------------------
module hvt_checker
  import hvt_pkg::*;
(
  input logic         clk_i,
  input logic         rst_ni,
  input logic         s_axis_tready,
  input logic         m_axis_tvalid,
  input logic         m_axis_tready,
  input logic [127:0] m_axis_tdata,
  input logic [1:0]   m_axis_tuser
);

  // an empty output register never blocks input
  a_ready_when_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !m_axis_tvalid |-> s_axis_tready)
    else $error("input stalled with empty output");

  // a stalled result holds
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
      && $stable(m_axis_tuser))
    else $error("stalled result changed");

  // divide-by-zero flag only with zero w
  a_dz_w: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser[TUSER_DZ_BIT] |-> m_axis_tdata[127:96] == 32'd0)
    else $error("div_by_zero with nonzero w");

  // a stalled output blocks the input
  a_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |-> !s_axis_tready)
    else $error("input accepted while output stalled");

endmodule

bind homogeneous_vertex_transform_core hvt_checker u_hvt_checker (.*);
